// ===== rtl/hcr_pkg.sv =====
package hcr_pkg;

    localparam int ID_W    = 6;
    localparam int PORT_W  = 3;
    localparam int HOP_W   = 5;
    localparam int DIST_W  = 16;
    localparam int PORTS   = 6;

    localparam logic [DIST_W-1:0] DIST_INF = 16'hFFFF;
    localparam logic [HOP_W-1:0]  HOP_MAX  = 5'd31;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PS_RD,
        S_PS_CK,
        S_INIT,
        S_MIN,
        S_SEL,
        S_RX_RD,
        S_RX_NB,
        S_RX_CK,
        S_WK_RD,
        S_WK_CK
    } t_state;

endpackage

// ===== rtl/hop_count_route_finder.sv =====
// Shortest-hop route finder over a table of module links. A word with cmd 0
// stores one link (module, port 1 to 6, neighbor id, 0 for no link) in the
// single cycle it is accepted and gives no result; the link table reads as
// all zero after reset through per-entry valid flags, so no clearing pass is
// needed. A word with cmd 1 asks for the source port toward a destination
// and always gives one result: o_valid is high for exactly one cycle with
// o_out_port, o_hop_count and o_route_found, and must be taken then, since
// the block cannot be held off. Bad ids, a destination equal to the source
// and an unreachable destination give port 0, hop count 0, found 0. While a
// query runs, busy is high and start is ignored. A direct neighbor is found
// by scanning the source's ports in order. Otherwise a breadth-first style
// search follows: the distance and predecessor memories are initialized,
// then for each extracted node a minimum scan runs through the distance
// memory's single read port and the node's ports are relaxed in turn; then
// the path is walked back through the predecessor memory and a final scan
// of the source's ports finds the port toward the first hop. The minimum
// scan and the per-port link reads dominate the run time.
module hop_count_route_finder #(
    parameter int NODES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [hcr_pkg::ID_W-1:0]    i_node_id,
    input  logic [hcr_pkg::PORT_W-1:0]  i_link_port,
    input  logic [hcr_pkg::ID_W-1:0]    i_neighbor_id,
    input  logic [hcr_pkg::ID_W-1:0]    i_source_id,
    input  logic [hcr_pkg::ID_W-1:0]    i_dest_id,
    output logic                        o_valid,
    output logic [hcr_pkg::PORT_W-1:0]  o_out_port,
    output logic [hcr_pkg::HOP_W-1:0]   o_hop_count,
    output logic                        o_route_found
);

    localparam int IDW    = hcr_pkg::ID_W;
    localparam int PW     = hcr_pkg::PORT_W;
    localparam int DW     = hcr_pkg::DIST_W;
    localparam int LDEPTH = NODES * hcr_pkg::PORTS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int IW     = $clog2(NODES);
    localparam int CW     = $clog2(NODES + 1);
    localparam int XW     = ((CW > IDW) ? CW : IDW) + 1;

    localparam logic [XW-1:0] NODES_X = XW'(NODES);
    localparam logic [PW-1:0] PORT_LAST = PW'(hcr_pkg::PORTS);

    // Link table address of a zero-based node index and a one-based port.
    function automatic logic [LAW-1:0] link_addr(input logic [XW-1:0] idx,
                                                 input logic [PW-1:0] port);
        logic [XW+3:0] a;
        a = ({4'd0, idx} << 2) + ({4'd0, idx} << 1) + (XW + 4)'(port) - (XW + 4)'(1);
        return a[LAW-1:0];
    endfunction

    // A missing or out-of-range neighbor reads as no link.
    function automatic logic [IDW-1:0] peer(input logic [IDW-1:0] id, input logic vld);
        if (!vld || XW'(id) > NODES_X) begin
            return '0;
        end
        return id;
    endfunction

    function automatic logic [XW-1:0] zidx(input logic [IDW-1:0] id);
        return XW'(id) - XW'(1);
    endfunction

    hcr_pkg::t_state r_state, n_state;

    logic [IDW-1:0]    r_src, n_src;
    logic [IDW-1:0]    r_dst, n_dst;
    logic [IDW-1:0]    r_target, n_target;
    logic              r_final, n_final;
    logic [PW-1:0]     r_p, n_p;
    logic [CW-1:0]     r_i, n_i;
    logic [DW-1:0]     r_best, n_best;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_hit, n_hit;
    logic [IDW-1:0]    r_v, n_v;
    logic [IDW-1:0]    r_hop1, n_hop1;
    logic [hcr_pkg::HOP_W-1:0] r_hops, n_hops;
    logic              r_lv, n_lv;
    logic [NODES-1:0]  r_vis, n_vis;
    logic [LDEPTH-1:0] r_lvld, n_lvld;
    logic              r_valid, n_valid;
    logic [PW-1:0]     r_oport, n_oport;
    logic [hcr_pkg::HOP_W-1:0] r_ohops, n_ohops;
    logic              r_ofound, n_ofound;

    logic           lwe;
    logic [LAW-1:0] lwaddr, lraddr;
    logic [IDW-1:0] lrdata;
    logic           dwe;
    logic [IW-1:0]  dwaddr, draddr;
    logic [DW-1:0]  dwdata, drdata;
    logic           pwe;
    logic [IW-1:0]  pwaddr, praddr;
    logic [IDW-1:0] pwdata, prdata;

    hcr_ram #(.WIDTH(IDW), .DEPTH(LDEPTH)) u_link (
        .i_clk(i_clk), .i_we(lwe), .i_waddr(lwaddr), .i_wdata(i_neighbor_id),
        .i_raddr(lraddr), .o_rdata(lrdata)
    );

    hcr_ram #(.WIDTH(DW), .DEPTH(NODES)) u_dist (
        .i_clk(i_clk), .i_we(dwe), .i_waddr(dwaddr), .i_wdata(dwdata),
        .i_raddr(draddr), .o_rdata(drdata)
    );

    hcr_ram #(.WIDTH(IDW), .DEPTH(NODES)) u_prev (
        .i_clk(i_clk), .i_we(pwe), .i_waddr(pwaddr), .i_wdata(pwdata),
        .i_raddr(praddr), .o_rdata(prdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_lvld  <= n_lvld;
            r_valid <= n_valid;
        end
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_target <= n_target;
        r_final  <= n_final;
        r_p      <= n_p;
        r_i      <= n_i;
        r_best   <= n_best;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_v      <= n_v;
        r_hop1   <= n_hop1;
        r_hops   <= n_hops;
        r_lv     <= n_lv;
        r_vis    <= n_vis;
        r_oport  <= n_oport;
        r_ohops  <= n_ohops;
        r_ofound <= n_ofound;
    end

    always_comb begin
        logic [IDW-1:0] id;
        logic [XW-1:0]  j;
        logic [DW-1:0]  alt;
        logic           next_port;
        logic           wk_done;

        n_state  = r_state;
        n_src    = r_src;
        n_dst    = r_dst;
        n_target = r_target;
        n_final  = r_final;
        n_p      = r_p;
        n_i      = r_i;
        n_best   = r_best;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_v      = r_v;
        n_hop1   = r_hop1;
        n_hops   = r_hops;
        n_lv     = r_lv;
        n_vis    = r_vis;
        n_lvld   = r_lvld;
        n_valid  = 1'b0;
        n_oport  = r_oport;
        n_ohops  = r_ohops;
        n_ofound = r_ofound;

        lwe    = 1'b0;
        lwaddr = link_addr(zidx(i_node_id), i_link_port);
        lraddr = '0;
        dwe    = 1'b0;
        dwaddr = '0;
        dwdata = '0;
        draddr = '0;
        pwe    = 1'b0;
        pwaddr = '0;
        pwdata = '0;
        praddr = '0;

        id        = peer(lrdata, r_lv);
        j         = XW'(r_i) - XW'(1);
        alt       = r_best + DW'(1);
        next_port = 1'b0;
        wk_done   = 1'b0;

        unique case (r_state)
            hcr_pkg::S_IDLE: begin
                if (start) begin
                    if (i_cmd == hcr_pkg::CMD_WRITE) begin
                        if (i_node_id != '0 && XW'(i_node_id) <= NODES_X &&
                            i_link_port != '0 && i_link_port <= PORT_LAST) begin
                            lwe = 1'b1;
                            n_lvld[lwaddr] = 1'b1;
                        end
                    end else begin
                        n_src = i_source_id;
                        n_dst = i_dest_id;
                        if (i_source_id == '0 || XW'(i_source_id) > NODES_X ||
                            i_dest_id == '0 || XW'(i_dest_id) > NODES_X ||
                            i_source_id == i_dest_id) begin
                            n_valid  = 1'b1;
                            n_oport  = '0;
                            n_ohops  = '0;
                            n_ofound = 1'b0;
                        end else begin
                            n_target = i_dest_id;
                            n_final  = 1'b0;
                            n_p      = PW'(1);
                            n_state  = hcr_pkg::S_PS_RD;
                        end
                    end
                end
            end
            hcr_pkg::S_PS_RD: begin
                lraddr  = link_addr(zidx(r_src), r_p);
                n_lv    = r_lvld[lraddr];
                n_state = hcr_pkg::S_PS_CK;
            end
            hcr_pkg::S_PS_CK: begin
                if (id != '0 && id == r_target) begin
                    n_valid  = 1'b1;
                    n_oport  = r_p;
                    n_ohops  = r_final ? r_hops : hcr_pkg::HOP_W'(1);
                    n_ofound = 1'b1;
                    n_state  = hcr_pkg::S_IDLE;
                end else if (r_p == PORT_LAST) begin
                    if (r_final) begin
                        n_valid  = 1'b1;
                        n_oport  = '0;
                        n_ohops  = '0;
                        n_ofound = 1'b0;
                        n_state  = hcr_pkg::S_IDLE;
                    end else begin
                        n_i     = '0;
                        n_state = hcr_pkg::S_INIT;
                    end
                end else begin
                    n_p     = r_p + PW'(1);
                    n_state = hcr_pkg::S_PS_RD;
                end
            end
            hcr_pkg::S_INIT: begin
                dwe    = 1'b1;
                dwaddr = r_i[IW-1:0];
                dwdata = (XW'(r_i) == zidx(r_src)) ? '0 : hcr_pkg::DIST_INF;
                pwe    = 1'b1;
                pwaddr = r_i[IW-1:0];
                pwdata = '0;
                if (r_i == CW'(NODES - 1)) begin
                    n_vis   = '0;
                    n_i     = '0;
                    n_best  = hcr_pkg::DIST_INF;
                    n_hit   = 1'b0;
                    n_state = hcr_pkg::S_MIN;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            hcr_pkg::S_MIN: begin
                // Read of entry i is issued while entry i-1 is compared.
                draddr = r_i[IW-1:0];
                if (r_i != '0) begin
                    if (!r_vis[j[IW-1:0]] && drdata < r_best) begin
                        n_best = drdata;
                        n_idx  = j[IW-1:0];
                        n_hit  = 1'b1;
                    end
                end
                if (r_i == CW'(NODES)) begin
                    n_state = hcr_pkg::S_SEL;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            hcr_pkg::S_SEL: begin
                if (!r_hit) begin
                    n_valid  = 1'b1;
                    n_oport  = '0;
                    n_ohops  = '0;
                    n_ofound = 1'b0;
                    n_state  = hcr_pkg::S_IDLE;
                end else if (XW'(r_idx) + XW'(1) == XW'(r_dst)) begin
                    n_hops  = (r_best > DW'(hcr_pkg::HOP_MAX)) ? hcr_pkg::HOP_MAX
                                                               : r_best[hcr_pkg::HOP_W-1:0];
                    n_hop1  = r_dst;
                    n_i     = '0;
                    n_state = hcr_pkg::S_WK_RD;
                end else begin
                    n_vis[r_idx] = 1'b1;
                    n_p          = PW'(1);
                    n_state      = hcr_pkg::S_RX_RD;
                end
            end
            hcr_pkg::S_RX_RD: begin
                lraddr  = link_addr(XW'(r_idx), r_p);
                n_lv    = r_lvld[lraddr];
                n_state = hcr_pkg::S_RX_NB;
            end
            hcr_pkg::S_RX_NB: begin
                j = zidx(id);
                if (id != '0 && !r_vis[j[IW-1:0]]) begin
                    draddr  = j[IW-1:0];
                    n_v     = id;
                    n_state = hcr_pkg::S_RX_CK;
                end else begin
                    next_port = 1'b1;
                end
            end
            hcr_pkg::S_RX_CK: begin
                j = zidx(r_v);
                if (alt < drdata) begin
                    dwe    = 1'b1;
                    dwaddr = j[IW-1:0];
                    dwdata = alt;
                    pwe    = 1'b1;
                    pwaddr = j[IW-1:0];
                    pwdata = IDW'(XW'(r_idx) + XW'(1));
                end
                next_port = 1'b1;
            end
            hcr_pkg::S_WK_RD: begin
                j       = zidx(r_hop1);
                praddr  = j[IW-1:0];
                n_state = hcr_pkg::S_WK_CK;
            end
            hcr_pkg::S_WK_CK: begin
                if (prdata == '0 || prdata == r_src) begin
                    wk_done = 1'b1;
                end else begin
                    n_hop1 = prdata;
                    if (r_i == CW'(NODES - 1)) begin
                        wk_done = 1'b1;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = hcr_pkg::S_WK_RD;
                    end
                end
            end
            default: begin
                n_state = hcr_pkg::S_IDLE;
            end
        endcase

        // The first hop is known: find the source port that reaches it.
        if (wk_done) begin
            n_target = n_hop1;
            n_final  = 1'b1;
            n_p      = PW'(1);
            n_state  = hcr_pkg::S_PS_RD;
        end

        if (next_port) begin
            if (r_p == PORT_LAST) begin
                n_i     = '0;
                n_best  = hcr_pkg::DIST_INF;
                n_hit   = 1'b0;
                n_state = hcr_pkg::S_MIN;
            end else begin
                n_p     = r_p + PW'(1);
                n_state = hcr_pkg::S_RX_RD;
            end
        end
    end

    assign busy          = (r_state != hcr_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_out_port    = r_oport;
    assign o_hop_count   = r_ohops;
    assign o_route_found = r_ofound;

    // A result only follows a query, which always leaves the block busy or
    // is rejected in the idle cycle it arrives.
    a_valid_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || ($past(start) && $past(i_cmd) == hcr_pkg::CMD_QUERY)))
        else $error("result without a query");

    a_found_has_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_route_found) |-> (o_out_port != '0 && o_hop_count != '0))
        else $error("route found without port or hop count");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_route_found) |-> (o_out_port == '0 && o_hop_count == '0))
        else $error("missing route with nonzero fields");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !(n_state != hcr_pkg::S_IDLE)) |=> o_valid)
        else $error("query ended without a result");

endmodule

// ===== rtl/hcr_ram.sv =====
module hcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES       = 32;
    localparam int ITEM_COUNT  = 580;
    localparam int CYCLE_LIMIT = 3000000;
    // Covers any work still in flight.
    localparam int SETTLE_CYCLES = 2500;

    localparam int   ID_W      = hcr_pkg::ID_W;
    localparam int   PORT_W    = hcr_pkg::PORT_W;
    localparam int   HOP_W     = hcr_pkg::HOP_W;
    localparam int   PORTS     = hcr_pkg::PORTS;
    localparam int   DIST_INF  = int'(hcr_pkg::DIST_INF);
    localparam int   HOP_MAX   = int'(hcr_pkg::HOP_MAX);
    localparam logic CMD_WRITE = hcr_pkg::CMD_WRITE;
    localparam logic CMD_QUERY = hcr_pkg::CMD_QUERY;

    // One word offered to the block, plus a flag that makes the driver wait
    // until every outstanding route result has come back before offering it.
    typedef struct {
        logic              cmd;
        logic [ID_W-1:0]   node_id;
        logic [PORT_W-1:0] link_port;
        logic [ID_W-1:0]   neighbor_id;
        logic [ID_W-1:0]   source_id;
        logic [ID_W-1:0]   dest_id;
        bit                drain_first;
    } t_word;

    typedef struct {
        logic [PORT_W-1:0] out_port;
        logic [HOP_W-1:0]  hop_count;
        logic              route_found;
    } t_route;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic              i_cmd = CMD_WRITE;
    logic [ID_W-1:0]   i_node_id = '0;
    logic [PORT_W-1:0] i_link_port = '0;
    logic [ID_W-1:0]   i_neighbor_id = '0;
    logic [ID_W-1:0]   i_source_id = '0;
    logic [ID_W-1:0]   i_dest_id = '0;
    logic              o_valid;
    logic [PORT_W-1:0] o_out_port;
    logic [HOP_W-1:0]  o_hop_count;
    logic              o_route_found;

    hop_count_route_finder #(.NODES(NODES)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_node_id     (i_node_id),
        .i_link_port   (i_link_port),
        .i_neighbor_id (i_neighbor_id),
        .i_source_id   (i_source_id),
        .i_dest_id     (i_dest_id),
        .o_valid       (o_valid),
        .o_out_port    (o_out_port),
        .o_hop_count   (o_hop_count),
        .o_route_found (o_route_found)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Words waiting to be sent, the word currently offered, and the routes
    // the block still owes us, oldest first.
    t_word  pending_words[$];
    t_word  offered_word;
    t_route owed_routes[$];

    // Private copy of the link table, indexed by module and port, both 1-based.
    logic [ID_W-1:0] link_copy [1:NODES][1:PORTS];

    int  mismatches = 0;
    int  failures = 0;
    int  words_taken = 0;
    int  writes_taken = 0;
    int  queries_taken = 0;
    int  routes_found = 0;
    int  routes_checked = 0;
    int  cycle_count = 0;
    bit  stimulus_done = 1'b0;

    // Neighbor at a port, with stored ids beyond the last module read as no link.
    function automatic int peer_at(int node, int port);
        int id;
        id = link_copy[node][port];
        return (id > NODES) ? 0 : id;
    endfunction

    function automatic int first_port_to(int src, int target);
        for (int p = 1; p <= PORTS; p++) begin
            if (peer_at(src, p) != 0 && peer_at(src, p) == target) return p;
        end
        return 0;
    endfunction

    // Applies a word to the local table and, for a query, works out the route
    // by a unit-weight shortest path search that takes the lowest-numbered
    // module among those at the minimum distance.
    function automatic bit predict_route(input t_word w, output t_route r);
        int src, dst, p, u, best, pick, alt, first_hop, hops, pr;
        int hop_dist [1:NODES];
        int prev [1:NODES];
        bit done_node [1:NODES];
        r = '{out_port: '0, hop_count: '0, route_found: 1'b0};
        if (w.cmd == CMD_WRITE) begin
            if (w.node_id >= 1 && w.node_id <= NODES && w.link_port >= 1 &&
                    w.link_port <= PORTS) begin
                link_copy[w.node_id][w.link_port] = w.neighbor_id;
            end
            return 1'b0;
        end
        src = w.source_id;
        dst = w.dest_id;
        if (src < 1 || src > NODES || dst < 1 || dst > NODES || src == dst) return 1'b1;
        p = first_port_to(src, dst);
        if (p != 0) begin
            r = '{out_port: PORT_W'(p), hop_count: HOP_W'(1), route_found: 1'b1};
            return 1'b1;
        end
        for (int i = 1; i <= NODES; i++) begin
            hop_dist[i] = DIST_INF;
            prev[i] = 0;
            done_node[i] = 1'b0;
        end
        hop_dist[src] = 0;
        forever begin
            best = DIST_INF;
            pick = 0;
            for (int i = 1; i <= NODES; i++) begin
                if (!done_node[i] && hop_dist[i] < best) begin
                    best = hop_dist[i];
                    pick = i;
                end
            end
            if (pick == 0) return 1'b1;
            u = pick;
            if (u == dst) break;
            done_node[u] = 1'b1;
            for (int q = 1; q <= PORTS; q++) begin
                int v;
                v = peer_at(u, q);
                if (v != 0 && !done_node[v]) begin
                    alt = best + 1;
                    if (alt < hop_dist[v]) begin
                        hop_dist[v] = alt;
                        prev[v] = u;
                    end
                end
            end
        end
        // Walk back to the module that the source enters first.
        first_hop = dst;
        for (int i = 0; i < NODES; i++) begin
            pr = prev[first_hop];
            if (pr == 0 || pr == src) break;
            first_hop = pr;
        end
        hops = (hop_dist[dst] > HOP_MAX) ? HOP_MAX : hop_dist[dst];
        p = first_port_to(src, first_hop);
        if (p != 0) r = '{out_port: PORT_W'(p), hop_count: HOP_W'(hops), route_found: 1'b1};
        return 1'b1;
    endfunction

    task automatic add_link(input int node, input int port, input int nb);
        t_word w;
        w = '{cmd: CMD_WRITE, node_id: ID_W'(node), link_port: PORT_W'(port),
              neighbor_id: ID_W'(nb), source_id: ID_W'($urandom),
              dest_id: ID_W'($urandom), drain_first: 1'b0};
        pending_words.push_back(w);
    endtask

    task automatic add_query(input int src, input int dst, input bit drain);
        t_word w;
        w = '{cmd: CMD_QUERY, node_id: ID_W'($urandom), link_port: PORT_W'($urandom),
              neighbor_id: ID_W'($urandom), source_id: ID_W'(src),
              dest_id: ID_W'(dst), drain_first: drain};
        pending_words.push_back(w);
    endtask

    // Driver: a word is taken at an edge where start is high and busy is low.
    // A new word is only put up once the previous one has been taken, and
    // idle gaps are skipped while the calm stretch of the run is active.
    t_route drv_route;
    bit     drv_fire;
    bit     drv_idle;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drv_fire = start && !busy;
            if (drv_fire) begin
                words_taken++;
                if (offered_word.cmd == CMD_WRITE) writes_taken++;
                else queries_taken++;
                if (predict_route(offered_word, drv_route)) owed_routes.push_back(drv_route);
            end
            if (drv_fire || !start) begin
                drv_idle = !(words_taken >= 250 && words_taken < 340) &&
                           ($urandom_range(99) < 38);
                if (pending_words.size() > 0 && !drv_idle &&
                        !(pending_words[0].drain_first && owed_routes.size() > 0)) begin
                    offered_word = pending_words.pop_front();
                    i_cmd         <= offered_word.cmd;
                    i_node_id     <= offered_word.node_id;
                    i_link_port   <= offered_word.link_port;
                    i_neighbor_id <= offered_word.neighbor_id;
                    i_source_id   <= offered_word.source_id;
                    i_dest_id     <= offered_word.dest_id;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest route still owed.
    t_route mon_want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (owed_routes.size() == 0) begin
                failures++;
                $display("Unexpected route result: port %0d hops %0d found %0d",
                         o_out_port, o_hop_count, o_route_found);
            end else begin
                mon_want = owed_routes.pop_front();
                routes_checked++;
                if (mon_want.route_found) routes_found++;
                if (o_out_port !== mon_want.out_port || o_hop_count !== mon_want.hop_count ||
                        o_route_found !== mon_want.route_found) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Route mismatch %0d: expected port %0d hops %0d found %0d,",
                                 routes_checked, mon_want.out_port, mon_want.hop_count,
                                 mon_want.route_found,
                                 " got port %0d hops %0d found %0d",
                                 o_out_port, o_hop_count, o_route_found);
                    end
                end
            end
        end
    end

    // A hung block must not hang the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("hop_count_route_finder test failed");
            $finish;
        end
    end

    initial begin
        int random_count;
        for (int n = 1; n <= NODES; n++) begin
            for (int p = 1; p <= PORTS; p++) link_copy[n][p] = '0;
        end

        // Empty table: every query is unreachable; bad ids and a destination
        // equal to the source give no route either.
        add_query(1, 32, 1'b0);
        add_query(0, 5, 1'b0);
        add_query(5, 63, 1'b0);
        add_query(33, 1, 1'b0);
        add_query(7, 7, 1'b0);
        // Writes with a bad module or port must leave the table alone.
        add_link(0, 1, 2);
        add_link(33, 2, 1);
        add_link(3, 0, 4);
        add_link(3, 7, 4);
        // A neighbor id beyond the last module reads as no link.
        add_link(3, 1, 40);
        add_query(3, 8, 1'b0);
        // A chain through every module gives the longest possible path.
        for (int n = 1; n < NODES; n++) add_link(n, 1, n + 1);
        add_query(1, 32, 1'b0);
        add_query(1, 2, 1'b0);
        add_query(32, 1, 1'b0);
        // Direct neighbor on the last port, and a detour back to the start.
        add_link(32, 6, 1);
        add_query(32, 1, 1'b0);
        add_query(31, 2, 1'b0);
        add_link(63 & 63, 5, 63);

        // Random part: link writes that grow and prune the topology mixed with
        // queries, with a wait for all results every hundred words or so.
        random_count = ITEM_COUNT - pending_words.size();
        for (int k = 0; k < random_count; k++) begin
            if ($urandom_range(99) < 50) begin
                int node, port, nb;
                node = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, NODES);
                port = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, PORTS);
                case ($urandom_range(19))
                    0, 1, 2: nb = 0;
                    3, 4:    nb = $urandom_range(NODES + 1, 63);
                    default: nb = $urandom_range(1, NODES);
                endcase
                add_link(node, port, nb);
            end else begin
                int src, dst;
                src = ($urandom_range(12) == 0) ? $urandom_range(63) : $urandom_range(1, NODES);
                dst = ($urandom_range(12) == 0) ? $urandom_range(63) : $urandom_range(1, NODES);
                add_query(src, dst, (k % 100) == 99);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0);
        @(posedge i_clk);
        while (start || owed_routes.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d link writes and %0d route queries.",
                 words_taken, writes_taken, queries_taken);
        $display("Checked %0d route results, %0d of them with a route found.",
                 routes_checked, routes_found);
        if (failures == 0 && owed_routes.size() == 0) begin
            $display("hop_count_route_finder test passed");
        end else begin
            $display("%0d failures, %0d results never arrived", failures, owed_routes.size());
            $display("hop_count_route_finder test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hcr_pkg.sv
rtl/hcr_ram.sv
rtl/hop_count_route_finder.sv
tb/sv/tb_top.sv
